// File: sv/sga_pkg.sv
// shared types, constants and helper functions for the softened gravity accumulator
// no dependencies; used by every module of the block but sga_queue
`timescale 1ns / 1ps

package sga_pkg;

	localparam int COORD_BITS_DEF = 32;

	localparam logic [63:0] POS_LIM = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_LIM = 64'h8000_0000_0000_0000;

	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SOFTENING = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN      = 2'd1;

	// flags that travel with each queued transaction
	typedef struct packed {
		logic last;
		logic zero;
		logic neg_y;
		logic neg_x;
	} flags_t;

	typedef struct packed {
		logic        ovf;
		logic [63:0] val;
	} clamp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_SQRT,
		ST_MULDEN,
		ST_MULNX,
		ST_DIVX,
		ST_MULNY,
		ST_DIVY,
		ST_SCALEX,
		ST_SCALEY,
		ST_EMIT
	} state_t;

	// clamp a magnitude to the signed 64-bit limit and apply the sign
	function automatic clamp_t clamp64(logic [63:0] mag, logic hi, logic neg);
		clamp_t      r;
		logic [63:0] lim;
		lim   = neg ? NEG_LIM : POS_LIM;
		r.ovf = hi || (mag > lim);
		r.val = r.ovf ? lim : mag;
		if (neg) begin
			r.val = 64'd0 - r.val;
		end
		return r;
	endfunction

	// signed 64-bit add with saturation
	function automatic clamp_t sat_add(logic [63:0] a, logic [63:0] b);
		clamp_t      r;
		logic [63:0] s;
		s     = a + b;
		r.ovf = (a[63] == b[63]) && (s[63] != a[63]);
		r.val = r.ovf ? (a[63] ? NEG_LIM : POS_LIM) : s;
		return r;
	endfunction

endpackage

// File: sv/softened_gravity_accumulator_core.sv
// top level of the softened gravity accumulator: configuration registers,
// front end, queue and back end; depends on sga_pkg, sga_front, sga_queue, sga_back
`timescale 1ns / 1ps

// Usage
// Input channel in_valid/in_ready carries one source body against one target per
// transaction; last marks the final source of a target. The output channel
// out_valid/out_ready carries one acceleration per target, with saturated set when
// any term, sum or scaled result was clamped since the previous result.
// Registers are written via cfg_we/cfg_index/cfg_data, by the user only while idle
// (not enforced by the block): index 0 softening, 1 gravity gain, others ignored.
// Timing: the front end takes a transaction in any cycle in which the two-entry
// queue has room. The back end works on one transaction at a time over a shared
// shift-add multiplier (one multiplier bit a cycle, stopping when the remaining
// bits are zero), a square root and two restoring divides. A source at the target
// skips these steps. The last transaction of a target adds two scales and a load of
// the result register.
// Reset clears the sums, the flag, the queue and the result valid and sets
// softening to 1 and the gain to 1.0. A stalled receiver holds the result register;
// the back end then waits before its next result while the front end keeps filling.

module softened_gravity_accumulator_core #(
	parameter int COORD_BITS = sga_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sga_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [31:0]                        cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [COORD_BITS-1:0]              target_x,
	input  logic [COORD_BITS-1:0]              target_y,
	input  logic [COORD_BITS-1:0]              source_x,
	input  logic [COORD_BITS-1:0]              source_y,
	input  logic [31:0]                        source_mass,
	input  logic                               last,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [63:0]                        accel_x,
	output logic [63:0]                        accel_y,
	output logic                               saturated
);

	localparam int EW = 2 * (COORD_BITS + 1) + 36;

	logic [31:0]   softening_q, gain_q;
	logic          push, q_full, q_valid, q_pop;
	logic [EW-1:0] push_data, pop_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			softening_q <= 32'd1;
			gain_q      <= 32'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sga_pkg::REG_SOFTENING: softening_q <= cfg_data;
				sga_pkg::REG_GAIN:      gain_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sga_front #(.COORD_BITS(COORD_BITS)) u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.target_x    (target_x),
		.target_y    (target_y),
		.source_x    (source_x),
		.source_y    (source_y),
		.source_mass (source_mass),
		.last        (last),
		.push        (push),
		.q_full      (q_full),
		.push_data   (push_data)
	);

	sga_queue #(.WIDTH(EW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (pop_data)
	);

	sga_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (pop_data),
		.q_pop        (q_pop),
		.softening    (softening_q),
		.gravity_gain (gain_q),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.accel_x      (accel_x),
		.accel_y      (accel_y),
		.saturated    (saturated)
	);

endmodule

// File: sv/sga_front.sv
// front end: takes input transactions, forms |dx|, |dy|, signs and flags
// depends on sga_pkg; feeds sga_queue
`timescale 1ns / 1ps

module sga_front #(
	parameter int COORD_BITS = sga_pkg::COORD_BITS_DEF,
	localparam int AW = COORD_BITS + 1,
	localparam int EW = 2 * AW + 36
) (
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] target_x,
	input  logic [COORD_BITS-1:0] target_y,
	input  logic [COORD_BITS-1:0] source_x,
	input  logic [COORD_BITS-1:0] source_y,
	input  logic [31:0]           source_mass,
	input  logic                  last,
	output logic                  push,
	input  logic                  q_full,
	output logic [EW-1:0]         push_data
);

	logic [AW-1:0] dx, dy, ax, ay;
	sga_pkg::flags_t flags;

	// differences in one extra bit, then magnitude and sign
	always_comb begin
		dx = {source_x[COORD_BITS-1], source_x} - {target_x[COORD_BITS-1], target_x};
		dy = {source_y[COORD_BITS-1], source_y} - {target_y[COORD_BITS-1], target_y};
		flags.neg_x = dx[AW-1];
		flags.neg_y = dy[AW-1];
		ax = dx[AW-1] ? (AW'(0) - dx) : dx;
		ay = dy[AW-1] ? (AW'(0) - dy) : dy;
		flags.zero = (dx == '0) && (dy == '0);
		flags.last = last;
	end

	assign in_ready  = !q_full;
	assign push      = in_valid && !q_full;
	assign push_data = {flags, source_mass, ay, ax};

endmodule

// File: sv/sga_queue.sv
// two-entry queue between front and back end
// depends on nothing but its width parameter
`timescale 1ns / 1ps

module sga_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       count_q;

	assign full     = (count_q == 2'd2);
	assign valid    = (count_q != 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/sga_back.sv
// back end: sequencer over a shared shift-add multiplier, square root and divider
// depends on sga_pkg; reads sga_queue, owns the sums and the result register
`timescale 1ns / 1ps

module sga_back #(
	parameter int COORD_BITS = sga_pkg::COORD_BITS_DEF,
	localparam int AW = COORD_BITS + 1,
	localparam int EW = 2 * AW + 36
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  logic [EW-1:0] q_data,
	output logic          q_pop,
	input  logic [31:0]   softening,
	input  logic [31:0]   gravity_gain,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [63:0]   accel_x,
	output logic [63:0]   accel_y,
	output logic          saturated
);

	localparam int R2W = 2 * AW + 2;
	localparam int SW  = AW + 17;
	localparam int DW  = R2W + SW;
	localparam int NW  = AW + 80;
	localparam int PW  = (DW > 96) ? DW : 96;
	localparam int MW  = (SW > 32) ? SW : 32;
	localparam int CW  = $clog2(NW + 1);

	sga_pkg::state_t state_q, state_d;

	// unpacked queue head
	logic [AW-1:0]   h_ax, h_ay;
	logic [31:0]     h_mass;
	sga_pkg::flags_t h_flags;
	assign {h_flags, h_mass, h_ay, h_ax} = q_data;

	// working registers
	logic [AW-1:0]  ax_q, ay_q;
	logic [31:0]    mass_q;
	sga_pkg::flags_t flags_q;
	logic [PW-1:0]  acc_q, mcand_q;
	logic [MW-1:0]  mplier_q;
	logic [R2W-1:0] r2_q;
	logic [2*SW-1:0] rad_q;
	logic [SW:0]    srem_q;
	logic [SW-1:0]  root_q;
	logic [DW-1:0]  den_q, drem_q;
	logic [NW-1:0]  num_q;
	logic [63:0]    quo_q;
	logic           quo_hi_q;
	logic [CW-1:0]  cnt_q;
	logic [63:0]    sum_x_q, sum_y_q, res_x_q;
	logic           ovf_q, sat_x_q;
	logic [63:0]    acc_x_q, acc_y_q;
	logic           out_valid_q, sat_out_q;

	logic mul_done, cnt_zero, emit_ok;
	assign mul_done = (mplier_q == '0);
	assign cnt_zero = (cnt_q == '0);
	assign emit_ok  = !out_valid_q || out_ready;

	// square root step
	logic [SW+2:0] s_sh, s_trial;
	logic          s_ge;
	// divide step
	logic [DW:0]   d_sh;
	logic          d_ge;
	// result of the current divide and of the current scale
	sga_pkg::clamp_t term_c, add_x_c, add_y_c, scale_c;
	logic [63:0]   mag_x, mag_y;

	always_comb begin
		s_sh    = {srem_q, rad_q[2*SW-1 -: 2]};
		s_trial = (SW + 3)'({root_q, 2'b01});
		s_ge    = (s_sh >= s_trial);
		d_sh    = {drem_q, num_q[NW-1]};
		d_ge    = (d_sh >= {1'b0, den_q});
		term_c  = sga_pkg::clamp64(quo_q, quo_hi_q,
			(state_q == sga_pkg::ST_DIVX) ? flags_q.neg_x : flags_q.neg_y);
		add_x_c = sga_pkg::sat_add(sum_x_q, term_c.val);
		add_y_c = sga_pkg::sat_add(sum_y_q, term_c.val);
		scale_c = sga_pkg::clamp64(acc_q[79:16], |acc_q[PW-1:80],
			(state_q == sga_pkg::ST_SCALEX) ? sum_x_q[63] : sum_y_q[63]);
		mag_x   = sum_x_q[63] ? (64'd0 - sum_x_q) : sum_x_q;
		mag_y   = sum_y_q[63] ? (64'd0 - sum_y_q) : sum_y_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sga_pkg::ST_IDLE: begin
				if (q_valid) begin
					if (!h_flags.zero) begin
						state_d = sga_pkg::ST_SQX;
					end else if (h_flags.last) begin
						state_d = sga_pkg::ST_SCALEX;
					end
				end
			end
			sga_pkg::ST_SQX:    if (mul_done) state_d = sga_pkg::ST_SQY;
			sga_pkg::ST_SQY:    if (mul_done) state_d = sga_pkg::ST_SQRT;
			sga_pkg::ST_SQRT:   if (cnt_zero) state_d = sga_pkg::ST_MULDEN;
			sga_pkg::ST_MULDEN: if (mul_done) state_d = sga_pkg::ST_MULNX;
			sga_pkg::ST_MULNX:  if (mul_done) state_d = sga_pkg::ST_DIVX;
			sga_pkg::ST_DIVX:   if (cnt_zero) state_d = sga_pkg::ST_MULNY;
			sga_pkg::ST_MULNY:  if (mul_done) state_d = sga_pkg::ST_DIVY;
			sga_pkg::ST_DIVY: begin
				if (cnt_zero) begin
					state_d = flags_q.last ? sga_pkg::ST_SCALEX : sga_pkg::ST_IDLE;
				end
			end
			sga_pkg::ST_SCALEX: if (mul_done) state_d = sga_pkg::ST_SCALEY;
			sga_pkg::ST_SCALEY: if (mul_done) state_d = sga_pkg::ST_EMIT;
			sga_pkg::ST_EMIT:   if (emit_ok) state_d = sga_pkg::ST_IDLE;
			default:            state_d = sga_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop = (state_q == sga_pkg::ST_IDLE) && q_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sga_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath: operands are loaded in the last cycle of the step before
	always_ff @(posedge clk) begin
		unique case (state_q)
			sga_pkg::ST_IDLE: begin
				ax_q    <= h_ax;
				ay_q    <= h_ay;
				mass_q  <= h_mass;
				flags_q <= h_flags;
				if (!h_flags.zero) begin
					acc_q    <= PW'(softening);
					mcand_q  <= PW'(h_ax);
					mplier_q <= MW'(h_ax);
				end else begin
					acc_q    <= '0;
					mcand_q  <= PW'(mag_x);
					mplier_q <= MW'(gravity_gain);
				end
			end
			sga_pkg::ST_SQRT: begin
				if (!cnt_zero) begin
					srem_q <= s_ge ? (SW + 1)'(s_sh - s_trial) : (SW + 1)'(s_sh);
					root_q <= {root_q[SW-2:0], s_ge};
					rad_q  <= {rad_q[2*SW-3:0], 2'b00};
					cnt_q  <= cnt_q - CW'(1);
				end else begin
					acc_q    <= '0;
					mcand_q  <= PW'(r2_q);
					mplier_q <= MW'(root_q);
				end
			end
			sga_pkg::ST_DIVX, sga_pkg::ST_DIVY: begin
				if (!cnt_zero) begin
					drem_q   <= d_ge ? DW'(d_sh - {1'b0, den_q}) : DW'(d_sh);
					quo_hi_q <= quo_hi_q | quo_q[63];
					quo_q    <= {quo_q[62:0], d_ge};
					num_q    <= {num_q[NW-2:0], 1'b0};
					cnt_q    <= cnt_q - CW'(1);
				end else if (state_q == sga_pkg::ST_DIVX) begin
					acc_q    <= '0;
					mcand_q  <= PW'(ay_q);
					mplier_q <= MW'(mass_q);
				end else begin
					acc_q    <= '0;
					mcand_q  <= PW'(mag_x);
					mplier_q <= MW'(gravity_gain);
				end
			end
			sga_pkg::ST_EMIT: begin
				if (emit_ok) begin
					acc_x_q   <= res_x_q;
					acc_y_q   <= scale_c.val;
					sat_out_q <= ovf_q;
				end
			end
			default: begin
				// multiply states: one multiplier bit per cycle
				if (!mul_done) begin
					if (mplier_q[0]) begin
						acc_q <= acc_q + mcand_q;
					end
					mcand_q  <= {mcand_q[PW-2:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[MW-1:1]};
				end else begin
					unique case (state_q)
						sga_pkg::ST_SQX: begin
							mcand_q  <= PW'(ay_q);
							mplier_q <= MW'(ay_q);
						end
						sga_pkg::ST_SQY: begin
							r2_q   <= acc_q[R2W-1:0];
							rad_q  <= {acc_q[R2W-1:0], 32'd0};
							srem_q <= '0;
							root_q <= '0;
							cnt_q  <= CW'(SW);
						end
						sga_pkg::ST_MULDEN: begin
							den_q    <= acc_q[DW-1:0];
							acc_q    <= '0;
							mcand_q  <= PW'(ax_q);
							mplier_q <= MW'(mass_q);
						end
						sga_pkg::ST_MULNX, sga_pkg::ST_MULNY: begin
							num_q    <= {acc_q[AW+31:0], 48'd0};
							drem_q   <= '0;
							quo_q    <= '0;
							quo_hi_q <= 1'b0;
							cnt_q    <= CW'(NW);
						end
						sga_pkg::ST_SCALEX: begin
							res_x_q  <= scale_c.val;
							acc_q    <= '0;
							mcand_q  <= PW'(mag_y);
							mplier_q <= MW'(gravity_gain);
						end
						default: begin
							// scale of y: result stays in acc until the emit
						end
					endcase
				end
			end
		endcase
	end

	// sums, overflow flags and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q     <= '0;
			sum_y_q     <= '0;
			ovf_q       <= 1'b0;
			sat_x_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == sga_pkg::ST_EMIT) && emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			priority if ((state_q == sga_pkg::ST_DIVX) && cnt_zero) begin
				sum_x_q <= add_x_c.val;
				ovf_q   <= ovf_q | term_c.ovf | add_x_c.ovf;
			end else if ((state_q == sga_pkg::ST_DIVY) && cnt_zero) begin
				sum_y_q <= add_y_c.val;
				ovf_q   <= ovf_q | term_c.ovf | add_y_c.ovf;
			end else if ((state_q == sga_pkg::ST_SCALEX) && mul_done) begin
				sat_x_q <= scale_c.ovf;
			end else if ((state_q == sga_pkg::ST_SCALEY) && mul_done) begin
				ovf_q <= ovf_q | sat_x_q | scale_c.ovf;
			end else if ((state_q == sga_pkg::ST_EMIT) && emit_ok) begin
				sum_x_q <= '0;
				sum_y_q <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign accel_x   = acc_x_q;
	assign accel_y   = acc_y_q;
	assign saturated = sat_out_q;

endmodule
